// ===== hw/rtl/tvs_pkg.sv =====
// ----------------------------------------------------------------------------
// tvs_pkg
// Shared types and constants of the trapezoid velocity scheduler.
// ----------------------------------------------------------------------------
package tvs_pkg;

    localparam logic [30:0] SAT31      = 31'h7FFF_FFFF;
    localparam logic [30:0] DT_LIMIT   = 31'd9830;   // 0.15 s
    localparam logic [13:0] DT_CLAMPED = 14'd6554;   // 0.1 s

    typedef enum logic [2:0] {
        REG_SEG_LEN    = 3'd0,
        REG_START_X    = 3'd1,
        REG_START_Y    = 3'd2,
        REG_TURN_RATE  = 3'd3,
        REG_TARGET_ROT = 3'd4,
        REG_MAX_SPEED  = 3'd5,
        REG_MAX_ACCEL  = 3'd6,
        REG_BRAKE_DIST = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic        [30:0] seg_len;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] turn_rate;
        logic signed [31:0] target_rotation;
        logic        [30:0] max_speed;
        logic        [30:0] max_accel;
        logic        [30:0] brake_distance;
    } t_cfg;

    // classified tick, front to back
    typedef struct packed {
        logic        [30:0] ax;
        logic        [30:0] ay;
        logic               dsat;
        logic signed [31:0] vel;
        logic        [13:0] dt;
        logic signed [63:0] rot;
    } t_tick;

    typedef struct packed {
        logic signed [31:0] vel;
        logic               dsat;
        logic               rot_done;
        logic        [44:0] p;
        logic        [61:0] sqx;
        logic        [61:0] sqy;
    } t_s1;

    typedef struct packed {
        logic signed [31:0] vel;
        logic               dsat;
        logic               rot_done;
        logic        [28:0] up;
        logic        [29:0] dn;
    } t_s2;

    typedef struct packed {
        logic signed [31:0] vel;
        logic               rot_done;
        logic        [28:0] up;
        logic        [29:0] dn;
        logic        [30:0] done;
        logic               at_goal;
        logic               brake;
        logic        [30:0] to_go;
    } t_s3;

endpackage

// ===== hw/rtl/tvs_sqrt.sv =====
// ----------------------------------------------------------------------------
// tvs_sqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tvs_sqrt #(
    parameter int W_IN   = 64,
    parameter int W_SIDE = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [W_IN-1:0]        i_rad,
    input  logic [W_SIDE-1:0]      i_side,
    output logic                   o_valid,
    output logic [W_IN/2-1:0]      o_root,
    output logic [W_SIDE-1:0]      o_side
);
    localparam int STAGES = W_IN / 2;
    localparam int W_ROOT = W_IN / 2;
    localparam int REM_W  = W_ROOT + 3;

    logic                r_v   [0:STAGES-1];
    logic [REM_W-1:0]    r_rem [0:STAGES-1];
    logic [W_ROOT-1:0]   r_q   [0:STAGES-1];
    logic [W_IN-1:0]     r_n   [0:STAGES-1];
    logic [W_SIDE-1:0]   r_s   [0:STAGES-1];

    logic                w_v   [0:STAGES];
    logic [REM_W-1:0]    w_rem [0:STAGES];
    logic [W_ROOT-1:0]   w_q   [0:STAGES];
    logic [W_IN-1:0]     w_n   [0:STAGES];
    logic [W_SIDE-1:0]   w_s   [0:STAGES];

    assign w_v[0]   = i_valid;
    assign w_rem[0] = '0;
    assign w_q[0]   = '0;
    assign w_n[0]   = i_rad;
    assign w_s[0]   = i_side;

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;

        assign cur   = {w_rem[k][REM_W-3:0], w_n[k][W_IN-1 -: 2]};
        assign trial = REM_W'({w_q[k], 2'b01});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (cur >= trial) begin
                r_rem[k] <= cur - trial;
                r_q[k]   <= {w_q[k][W_ROOT-2:0], 1'b1};
            end else begin
                r_rem[k] <= cur;
                r_q[k]   <= {w_q[k][W_ROOT-2:0], 1'b0};
            end
            r_n[k] <= {w_n[k][W_IN-3:0], 2'b00};
            r_s[k] <= w_s[k];
        end

        assign w_v[k+1]   = r_v[k];
        assign w_rem[k+1] = r_rem[k];
        assign w_q[k+1]   = r_q[k];
        assign w_n[k+1]   = r_n[k];
        assign w_s[k+1]   = r_s[k];
    end

    assign o_valid = w_v[STAGES];
    assign o_root  = w_q[STAGES];
    assign o_side  = w_s[STAGES];

endmodule

// ===== hw/rtl/tvs_div5.sv =====
// ----------------------------------------------------------------------------
// tvs_div5
// Pipelined divide by five, one hex digit of quotient per stage.
// ----------------------------------------------------------------------------
module tvs_div5 #(
    parameter int W_NUM  = 48,
    parameter int W_SIDE = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [W_NUM-1:0]   i_num,
    input  logic [W_SIDE-1:0]  i_side,
    output logic               o_valid,
    output logic [W_NUM-1:0]   o_quot,
    output logic [W_SIDE-1:0]  o_side
);
    localparam int STAGES = W_NUM / 4;

    logic               r_v   [0:STAGES-1];
    logic [2:0]         r_rem [0:STAGES-1];
    logic [W_NUM-1:0]   r_q   [0:STAGES-1];
    logic [W_NUM-1:0]   r_n   [0:STAGES-1];
    logic [W_SIDE-1:0]  r_s   [0:STAGES-1];

    logic               w_v   [0:STAGES];
    logic [2:0]         w_rem [0:STAGES];
    logic [W_NUM-1:0]   w_q   [0:STAGES];
    logic [W_NUM-1:0]   w_n   [0:STAGES];
    logic [W_SIDE-1:0]  w_s   [0:STAGES];

    assign w_v[0]   = i_valid;
    assign w_rem[0] = '0;
    assign w_q[0]   = '0;
    assign w_n[0]   = i_num;
    assign w_s[0]   = i_side;

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [6:0]  x;
        logic [14:0] xm;
        logic [3:0]  qd;
        logic [6:0]  q5;

        assign x  = {w_rem[k], w_n[k][W_NUM-1 -: 4]};
        // x < 80, so x*205/1024 is an exact floor(x/5)
        assign xm = {8'b0, x} * 15'd205;
        assign qd = xm[13:10];
        assign q5 = {1'b0, qd, 2'b00} + {3'b0, qd};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= 3'(x - q5);
            r_q[k]   <= {w_q[k][W_NUM-5:0], qd};
            r_n[k]   <= {w_n[k][W_NUM-5:0], 4'b0};
            r_s[k]   <= w_s[k];
        end

        assign w_v[k+1]   = r_v[k];
        assign w_rem[k+1] = r_rem[k];
        assign w_q[k+1]   = r_q[k];
        assign w_n[k+1]   = r_n[k];
        assign w_s[k+1]   = r_s[k];
    end

    assign o_valid = w_v[STAGES];
    assign o_quot  = w_q[STAGES];
    assign o_side  = w_s[STAGES];

endmodule

// ===== hw/rtl/tvs_front.sv =====
// ----------------------------------------------------------------------------
// tvs_front
// Takes a tick: clamps the interval, forms position offsets and the
// open-loop rotation product.
// ----------------------------------------------------------------------------
module tvs_front
    import tvs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  t_cfg               i_cfg,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_measured_speed,
    input  logic        [30:0] i_tick_interval,
    input  logic        [30:0] i_elapsed_time,
    output logic               o_valid,
    output t_tick              o_tick
);
    logic               r_valid;
    t_tick              r_tick;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic        [32:0] ax;
    logic        [32:0] ay;
    t_tick              n_tick;

    always_comb begin
        dx = {i_pos_x[31], i_pos_x} - {i_cfg.start_x[31], i_cfg.start_x};
        dy = {i_pos_y[31], i_pos_y} - {i_cfg.start_y[31], i_cfg.start_y};
        ax = dx[32] ? 33'(-dx) : 33'(dx);
        ay = dy[32] ? 33'(-dy) : 33'(dy);
        n_tick.ax   = ax[30:0];
        n_tick.ay   = ay[30:0];
        n_tick.dsat = ax[32] | ax[31] | ay[32] | ay[31];
        n_tick.vel  = i_measured_speed;
        n_tick.dt   = (i_tick_interval > DT_LIMIT) ? DT_CLAMPED : i_tick_interval[13:0];
        n_tick.rot  = i_cfg.turn_rate * $signed({1'b0, i_elapsed_time});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_tick <= n_tick;
        end
    end

    assign o_valid = r_valid;
    assign o_tick  = r_tick;

endmodule

// ===== hw/rtl/tvs_queue.sv =====
// ----------------------------------------------------------------------------
// tvs_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module tvs_queue
    import tvs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_tick i_data,
    input  logic  i_pop,
    output logic  o_valid,
    output logic  o_full,
    output t_tick o_data
);
    t_tick      r_mem [0:1];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       do_pop;

    assign do_pop = i_pop && (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd];

endmodule

// ===== hw/rtl/tvs_back.sv =====
// ----------------------------------------------------------------------------
// tvs_back
// Distance, speed schedule, ramp limit and rotation test, fully pipelined.
// ----------------------------------------------------------------------------
module tvs_back
    import tvs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_tick              i_tick,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    output logic signed [31:0] o_linear_command,
    output logic signed [31:0] o_angular_command,
    output logic        [30:0] o_distance_done,
    output logic               o_rotation_done,
    output logic               o_segment_complete
);
    // stage 0: squares, accel product, rotation test
    logic               r_v0;
    t_s1                r_s0;
    t_s1                n_s0;
    logic signed [63:0] tgt;

    always_comb begin
        tgt          = {{16{i_cfg.target_rotation[31]}}, i_cfg.target_rotation, 16'b0};
        n_s0.vel     = i_tick.vel;
        n_s0.dsat    = i_tick.dsat;
        n_s0.p       = {14'b0, i_cfg.max_accel} * {31'b0, i_tick.dt};
        n_s0.sqx     = {31'b0, i_tick.ax} * {31'b0, i_tick.ax};
        n_s0.sqy     = {31'b0, i_tick.ay} * {31'b0, i_tick.ay};
        if (i_cfg.turn_rate < 0) begin
            n_s0.rot_done = (i_tick.rot <= tgt);
        end else if (i_cfg.turn_rate > 0) begin
            n_s0.rot_done = (i_tick.rot >= tgt);
        end else begin
            n_s0.rot_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0 <= n_s0;
    end

    // p / 5 for the braking step
    logic        d_v;
    logic [47:0] d_q;
    t_s1         d_s;

    tvs_div5 #(
        .W_NUM  (48),
        .W_SIDE ($bits(t_s1))
    ) u_div5 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .i_num   ({3'b0, r_s0.p}),
        .i_side  (r_s0),
        .o_valid (d_v),
        .o_quot  (d_q),
        .o_side  (d_s)
    );

    // stage 1: ramp steps, sum of squares
    logic        r_v1;
    t_s2         r_s1;
    logic [62:0] r_sum;
    logic [45:0] dn_full;

    assign dn_full = {1'b0, d_s.p} + d_q[45:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1.vel      <= d_s.vel;
        r_s1.dsat     <= d_s.dsat;
        r_s1.rot_done <= d_s.rot_done;
        r_s1.up       <= d_s.p[44:16];
        r_s1.dn       <= dn_full[45:16];
        r_sum         <= {1'b0, d_s.sqx} + {1'b0, d_s.sqy};
    end

    logic        q1_v;
    logic [31:0] q1_root;
    t_s2         q1_s;

    tvs_sqrt #(
        .W_IN   (64),
        .W_SIDE ($bits(t_s2))
    ) u_sqrt_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_rad   ({1'b0, r_sum}),
        .i_side  (r_s1),
        .o_valid (q1_v),
        .o_root  (q1_root),
        .o_side  (q1_s)
    );

    // stage 2: distance, remaining distance, zone
    logic               r_v2;
    t_s3                r_s2;
    logic        [30:0] done;
    logic signed [31:0] to_go;

    always_comb begin
        done  = (q1_s.dsat || q1_root[31]) ? SAT31 : q1_root[30:0];
        to_go = $signed({1'b0, i_cfg.seg_len}) - $signed({1'b0, done});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= q1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2.vel      <= q1_s.vel;
        r_s2.rot_done <= q1_s.rot_done;
        r_s2.up       <= q1_s.up;
        r_s2.dn       <= q1_s.dn;
        r_s2.done     <= done;
        r_s2.at_goal  <= (to_go <= 0);
        r_s2.brake    <= (to_go <= $signed({1'b0, i_cfg.brake_distance}));
        r_s2.to_go    <= to_go[30:0];
    end

    // stage 3: 2*d*a radicand
    logic        r_v3;
    t_s3         r_s3;
    logic [61:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3   <= r_s2;
        r_prod <= {31'b0, r_s2.to_go} * {31'b0, i_cfg.max_accel};
    end

    logic        q2_v;
    logic [31:0] q2_root;
    t_s3         q2_s;

    tvs_sqrt #(
        .W_IN   (64),
        .W_SIDE ($bits(t_s3))
    ) u_sqrt_brake (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .i_rad   ({1'b0, r_prod, 1'b0}),
        .i_side  (r_s3),
        .o_valid (q2_v),
        .o_root  (q2_root),
        .o_side  (q2_s)
    );

    // stage 4: scheduled speed
    logic        r_v4;
    t_s3         r_s4;
    logic [30:0] r_sched;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= q2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4 <= q2_s;
        if (q2_s.at_goal) begin
            r_sched <= '0;
        end else if (q2_s.brake) begin
            r_sched <= q2_root[31] ? SAT31 : q2_root[30:0];
        end else begin
            r_sched <= i_cfg.max_speed;
        end
    end

    // stage 5: ramp limit and result register
    logic signed [33:0] vel34;
    logic signed [33:0] sched34;
    logic signed [33:0] test;
    logic signed [33:0] cmd;

    always_comb begin
        vel34   = {{2{r_s4.vel[31]}}, r_s4.vel};
        sched34 = $signed({3'b0, r_sched});
        test    = vel34;
        cmd     = sched34;
        if (vel34 < sched34) begin
            test = vel34 + $signed({5'b0, r_s4.up});
            cmd  = (test < sched34) ? test : sched34;
        end else if (vel34 > sched34) begin
            test = vel34 - $signed({4'b0, r_s4.dn});
            cmd  = (test > sched34) ? test : sched34;
        end
        if (r_s4.at_goal) begin
            cmd = '0;
        end
    end

    logic               r_valid;
    logic signed [31:0] r_lin;
    logic signed [31:0] r_ang;
    logic        [30:0] r_dist;
    logic               r_rot;
    logic               r_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lin  <= cmd[31:0];
        r_ang  <= r_s4.rot_done ? 32'sd0 : i_cfg.turn_rate;
        r_dist <= r_s4.done;
        r_rot  <= r_s4.rot_done;
        r_seg  <= r_s4.at_goal && r_s4.rot_done;
    end

    assign o_valid            = r_valid;
    assign o_linear_command   = r_lin;
    assign o_angular_command  = r_ang;
    assign o_distance_done    = r_dist;
    assign o_rotation_done    = r_rot;
    assign o_segment_complete = r_seg;

endmodule

// ===== hw/rtl/trapezoid_velocity_scheduler.sv =====
// ----------------------------------------------------------------------------
// trapezoid_velocity_scheduler
// Path from the accepting edge to o_valid: front, queue, 12 divide
// stages, two 32-stage square root pipelines, ramp stages.
// Throughput: one tick per cycle; the back end never stalls, so busy
// stays low and the queue holds at most one tick.
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults.
// ----------------------------------------------------------------------------
module trapezoid_velocity_scheduler
    import tvs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_measured_speed,
    input  logic        [30:0] i_tick_interval,
    input  logic        [30:0] i_elapsed_time,
    input  logic               i_cfg_we,
    input  logic        [2:0]  i_cfg_idx,
    input  logic        [31:0] i_cfg_data,
    output logic               o_valid,
    output logic signed [31:0] o_linear_command,
    output logic signed [31:0] o_angular_command,
    output logic        [30:0] o_distance_done,
    output logic               o_rotation_done,
    output logic               o_segment_complete
);
    t_cfg  r_cfg;
    logic  accept;
    logic  f_valid;
    t_tick f_tick;
    logic  q_valid;
    logic  q_full;
    t_tick q_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seg_len         <= '0;
            r_cfg.start_x         <= '0;
            r_cfg.start_y         <= '0;
            r_cfg.turn_rate       <= '0;
            r_cfg.target_rotation <= '0;
            r_cfg.max_speed       <= 31'd327680;
            r_cfg.max_accel       <= 31'd6554;
            r_cfg.brake_distance  <= 31'd8192000;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_SEG_LEN:    r_cfg.seg_len         <= i_cfg_data[30:0];
                REG_START_X:    r_cfg.start_x         <= i_cfg_data;
                REG_START_Y:    r_cfg.start_y         <= i_cfg_data;
                REG_TURN_RATE:  r_cfg.turn_rate       <= i_cfg_data;
                REG_TARGET_ROT: r_cfg.target_rotation <= i_cfg_data;
                REG_MAX_SPEED:  r_cfg.max_speed       <= i_cfg_data[30:0];
                REG_MAX_ACCEL:  r_cfg.max_accel       <= i_cfg_data[30:0];
                REG_BRAKE_DIST: r_cfg.brake_distance  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign busy   = q_full;
    assign accept = start && !busy;

    tvs_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_cfg            (r_cfg),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_measured_speed (i_measured_speed),
        .i_tick_interval  (i_tick_interval),
        .i_elapsed_time   (i_elapsed_time),
        .o_valid          (f_valid),
        .o_tick           (f_tick)
    );

    tvs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_tick),
        .i_pop   (1'b1),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_tick)
    );

    tvs_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (q_valid),
        .i_tick             (q_tick),
        .i_cfg              (r_cfg),
        .o_valid            (o_valid),
        .o_linear_command   (o_linear_command),
        .o_angular_command  (o_angular_command),
        .o_distance_done    (o_distance_done),
        .o_rotation_done    (o_rotation_done),
        .o_segment_complete (o_segment_complete)
    );

endmodule
